// ===== rtl/core/rotate_1bpp_frame_90_top_defines.svh =====
// Assertion macros shared by the frame rotator checker.
`ifndef ROTATE_1BPP_FRAME_90_TOP_DEFINES_SVH
`define ROTATE_1BPP_FRAME_90_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define ROT90_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ROT90_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rot90_pkg.sv =====
// Shared types and constants of the 1bpp frame rotator.
package rot90_pkg;

  // Operation codes carried in the input tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Eight bit banks, one per native row modulo eight
  localparam int NBANKS      = 8;
  localparam int BANK_ADDR_W = 16;

  // White byte: store reset value and out-of-range read value
  localparam logic [7:0] WHITE_BYTE = 8'hFF;
  localparam logic [7:0] MSB_BIT    = 8'h80;

  // Result queue depth
  localparam int FIFO_DEPTH = 8;

  // Bank access request, one per item, produced by the address pipeline
  typedef struct packed {
    logic                                     valid;
    logic                                     op;
    logic                                     in_range;
    logic [NBANKS-1:0]                        we;
    logic [NBANKS-1:0]                        bits;
    logic [7:0]                               mask;
    logic [2:0]                               rbank;
    logic [NBANKS-1:0][BANK_ADDR_W-1:0]       addr;
  } bank_req_t;

  // Queued read result
  typedef struct packed {
    logic       err;
    logic [7:0] data;
  } result_t;

endpackage

// ===== rtl/core/rotate_1bpp_frame_90_top.sv =====
// Top level of the 1bpp portrait-to-landscape frame rotator with banked frame store.
//
// Input channel s_axis: tuser is the operation (0 writes a portrait byte, 1 reads
// a native byte); tdata carries the byte address and, on writes, eight pixels.
// A write updates one bit in each of eight native rows; the rows sit in eight
// bit banks (native row modulo eight), each a one-port-write, one-port-read
// memory, so all eight bits are written in the same cycle by read-modify-write
// with forwarding from the previous write.
// Output channel m_axis: one beat per read, native byte in tdata, range error
// in tuser. Writes give no beat; out-of-range writes are dropped.
// Throughput: one item per cycle while s_axis_tready is high, writes and reads mixed in any order.
// A read beat passes through address division (reciprocal product, quotient
// estimate, correction), bank mapping, a memory read and a result queue write
// before it appears on m_axis.
// Reset: the store is swept to white, one address of all eight banks per cycle,
// ((PORTRAIT_WIDTH+7)/8)*((PORTRAIT_HEIGHT+7)/8) addresses (6000 at the defaults);
// s_axis_tready stays low until the sweep ends.
// Stall: read results wait in an eight-entry queue; s_axis_tready drops when
// eight reads are outstanding, and no beat is lost.
module rotate_1bpp_frame_90_top #(
  parameter int PORTRAIT_WIDTH  = 480,
  parameter int PORTRAIT_HEIGHT = 800
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] byte_address, [23:16] pixel_byte
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] native_byte
  output logic        m_axis_tuser    // [0] address_error
);

  localparam int NB         = rot90_pkg::NBANKS;
  localparam int BANK_ROWS  = (PORTRAIT_WIDTH + 7) / 8;
  localparam int NSTRIDE    = (PORTRAIT_HEIGHT + 7) / 8;
  localparam int BANK_DEPTH = BANK_ROWS * NSTRIDE;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int QW         = $clog2(rot90_pkg::FIFO_DEPTH);
  localparam int PW         = $clog2(rot90_pkg::FIFO_DEPTH + 1);

  logic                 in_beat;
  logic                 rd_beat;
  logic                 out_beat;
  rot90_pkg::bank_req_t req;

  // Clearing sweep
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  // Read-modify-write stage
  logic                 b_valid;
  rot90_pkg::bank_req_t b_req;
  logic [NB-1:0][7:0]   rd_data;
  logic [NB-1:0][7:0]   old_data;
  logic [NB-1:0][7:0]   new_data;
  logic [NB-1:0]        wen;
  logic [NB-1:0]        lw_valid;
  logic [NB-1:0][15:0]  lw_addr;
  logic [NB-1:0][7:0]   lw_data;

  // Result queue
  rot90_pkg::result_t fifo [rot90_pkg::FIFO_DEPTH];
  rot90_pkg::result_t res;
  logic               res_push;
  logic [QW-1:0]      wr_ptr;
  logic [QW-1:0]      rd_ptr;
  logic [PW-1:0]      fifo_count;
  logic [PW-1:0]      pending;

  // Accept while not clearing and queue space covers every outstanding read
  assign s_axis_tready = !clr_active && (pending < PW'(rot90_pkg::FIFO_DEPTH));
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign rd_beat       = in_beat && (s_axis_tuser == rot90_pkg::OP_READ);
  assign out_beat      = m_axis_tvalid && m_axis_tready;

  rot90_addr #(
    .PORTRAIT_WIDTH (PORTRAIT_WIDTH),
    .PORTRAIT_HEIGHT(PORTRAIT_HEIGHT)
  ) u_addr (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_beat),
    .op          (s_axis_tuser),
    .byte_address(s_axis_tdata[15:0]),
    .pixel_byte  (s_axis_tdata[23:16]),
    .req         (req)
  );

  // Sweep every bank address to white after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == AW'(BANK_DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Eight bit banks: read at the request address, write back one stage later
  for (genvar gb = 0; gb < NB; gb++) begin : g_bank
    logic [7:0] mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (clr_active) begin
        mem[clr_addr] <= rot90_pkg::WHITE_BYTE;
      end else if (wen[gb]) begin
        mem[b_req.addr[gb][AW-1:0]] <= new_data[gb];
      end
      rd_data[gb] <= mem[req.addr[gb][AW-1:0]];
    end
  end

  // Hold the request alongside its read data
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= req.valid;
    end
    b_req <= req;
  end

  // Forward the previous write over stale read data, then set or clear the bit
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      if (lw_valid[b] && (lw_addr[b] == b_req.addr[b])) begin
        old_data[b] = lw_data[b];
      end else begin
        old_data[b] = rd_data[b];
      end
      if (b_req.bits[b]) begin
        new_data[b] = old_data[b] | b_req.mask;
      end else begin
        new_data[b] = old_data[b] & ~b_req.mask;
      end
      wen[b] = b_valid && (b_req.op == rot90_pkg::OP_WRITE) && b_req.we[b];
    end
  end

  // Remember the write made at this edge for the next access
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= '0;
    end else begin
      lw_valid <= wen;
    end
    for (int b = 0; b < NB; b++) begin
      lw_addr[b] <= b_req.addr[b];
      lw_data[b] <= new_data[b];
    end
  end

  // Form the read result
  always_comb begin
    res_push = b_valid && (b_req.op == rot90_pkg::OP_READ);
    if (b_req.in_range) begin
      res.data = old_data[b_req.rbank];
      res.err  = 1'b0;
    end else begin
      res.data = rot90_pkg::WHITE_BYTE;
      res.err  = 1'b1;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (res_push) begin
      fifo[wr_ptr] <= res;
    end
  end

  // Queue pointers, fill level and outstanding read count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      pending    <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + QW'(1);
      end
      if (out_beat) begin
        rd_ptr <= rd_ptr + QW'(1);
      end
      fifo_count <= fifo_count + PW'(res_push) - PW'(out_beat);
      pending    <= pending + PW'(rd_beat) - PW'(out_beat);
    end
  end

  assign m_axis_tvalid = (fifo_count != '0);
  assign m_axis_tdata  = fifo[rd_ptr].data;
  assign m_axis_tuser  = fifo[rd_ptr].err;

endmodule

// ===== rtl/core/rot90_addr.sv =====
// Address pipeline: splits byte addresses into row and column, maps them to bank addresses.
module rot90_addr #(
  parameter int PORTRAIT_WIDTH  = 480,
  parameter int PORTRAIT_HEIGHT = 800
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 op,
  input  logic [15:0]          byte_address,
  input  logic [7:0]           pixel_byte,
  output rot90_pkg::bank_req_t req
);

  localparam int PSTRIDE = (PORTRAIT_WIDTH + 7) / 8;
  localparam int NSTRIDE = (PORTRAIT_HEIGHT + 7) / 8;
  localparam int PBYTES  = PORTRAIT_HEIGHT * PSTRIDE;
  localparam int SBYTES  = PORTRAIT_WIDTH * NSTRIDE;
  localparam logic [32:0] PRECIP = 33'((64'd1 << 32) / PSTRIDE);
  localparam logic [32:0] NRECIP = 33'((64'd1 << 32) / NSTRIDE);
  localparam logic [8:0]  PDIV   = 9'(PSTRIDE);
  localparam logic [8:0]  NDIV   = 9'(NSTRIDE);

  // Stage 1: reciprocal product
  logic        s1_valid;
  logic        s1_op;
  logic        s1_inr;
  logic [15:0] s1_addr;
  logic [7:0]  s1_pix;
  logic [47:0] s1_prod;

  // Stage 2: quotient estimate and its back-product
  logic        s2_valid;
  logic        s2_op;
  logic        s2_inr;
  logic [15:0] s2_addr;
  logic [7:0]  s2_pix;
  logic [15:0] s2_qe;
  logic [15:0] s2_qd;

  // Stage 3: corrected quotient and remainder
  logic        s3_valid;
  logic        s3_op;
  logic        s3_inr;
  logic [7:0]  s3_pix;
  logic [15:0] s3_q;
  logic [7:0]  s3_r;

  logic [32:0] recip;
  logic        inr;
  logic [15:0] qe_c;
  logic [8:0]  div2;
  logic [8:0]  div3;
  logic [15:0] rem;
  rot90_pkg::bank_req_t req_next;

  // Pick reciprocal and range limit by operation
  always_comb begin
    recip = (op == rot90_pkg::OP_READ) ? NRECIP : PRECIP;
    if (op == rot90_pkg::OP_READ) begin
      inr = ({16'd0, byte_address} < 32'(SBYTES));
    end else begin
      inr = ({16'd0, byte_address} < 32'(PBYTES));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_op   <= op;
    s1_inr  <= inr;
    s1_addr <= byte_address;
    s1_pix  <= pixel_byte;
    s1_prod <= 48'(byte_address) * 48'(recip);
  end

  // Take the quotient estimate and multiply it back
  always_comb begin
    qe_c = s1_prod[47:32];
    div2 = (s1_op == rot90_pkg::OP_READ) ? NDIV : PDIV;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_op   <= s1_op;
    s2_inr  <= s1_inr;
    s2_addr <= s1_addr;
    s2_pix  <= s1_pix;
    s2_qe   <= qe_c;
    s2_qd   <= 16'(25'(qe_c) * 25'(div2));
  end

  // Correct an estimate that fell one short
  always_comb begin
    div3 = (s2_op == rot90_pkg::OP_READ) ? NDIV : PDIV;
    rem  = s2_addr - s2_qd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_op  <= s2_op;
    s3_inr <= s2_inr;
    s3_pix <= s2_pix;
    if (rem >= 16'(div3)) begin
      s3_q <= s2_qe + 16'd1;
      s3_r <= 8'(rem - 16'(div3));
    end else begin
      s3_q <= s2_qe;
      s3_r <= 8'(rem);
    end
  end

  // Map row and column to per-bank addresses and bit updates
  always_comb begin
    int ib;
    int ny;
    int col;
    int grp;
    ib                = 0;
    ny                = 0;
    col               = 0;
    grp               = 0;
    req_next          = '0;
    req_next.valid    = s3_valid;
    req_next.op       = s3_op;
    req_next.in_range = s3_inr;
    req_next.mask     = rot90_pkg::MSB_BIT >> s3_q[2:0];
    req_next.rbank    = s3_q[2:0];
    for (int b = 0; b < rot90_pkg::NBANKS; b++) begin
      if (s3_op == rot90_pkg::OP_READ) begin
        col = int'(s3_r);
        grp = int'(s3_q >> 3);
        req_next.addr[b] = 16'(grp * NSTRIDE + col);
      end else begin
        ib  = (PORTRAIT_WIDTH - 1 - b) & 7;
        ny  = (PORTRAIT_WIDTH - 1) - 8 * int'(s3_r) - ib;
        col = int'(s3_q >> 3);
        grp = (ny >= 0) ? (ny >> 3) : 0;
        req_next.addr[b] = 16'(grp * NSTRIDE + col);
        req_next.we[b]   = s3_inr && (ny >= 0);
        req_next.bits[b] = s3_pix[7 - ib];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      req.valid <= req_next.valid;
    end
    req.op       <= req_next.op;
    req.in_range <= req_next.in_range;
    req.we       <= req_next.we;
    req.bits     <= req_next.bits;
    req.mask     <= req_next.mask;
    req.rbank    <= req_next.rbank;
    req.addr     <= req_next.addr;
  end

endmodule

// ===== rtl/core/rot90_chk.sv =====
// Port-level checker for the frame rotator, bound to the top level.
`include "rotate_1bpp_frame_90_top_defines.svh"

module rot90_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);

  logic [7:0] outstanding;

  // Count reads accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding
                     + 8'(s_axis_tvalid && s_axis_tready
                          && (s_axis_tuser == rot90_pkg::OP_READ))
                     - 8'(m_axis_tvalid && m_axis_tready);
    end
  end

  `ROT90_ASSERT_ALWAYS(a_sweep_blocks_input, rst |=> !s_axis_tready, "input taken during clear sweep")
  `ROT90_ASSERT(a_no_spurious_result, m_axis_tvalid |-> (outstanding != 8'd0), "result beat without a read")
  `ROT90_ASSERT(a_error_reads_white, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == rot90_pkg::WHITE_BYTE), "range error with non-white byte")
  `ROT90_ASSERT(a_outstanding_bound, outstanding <= 8'(rot90_pkg::FIFO_DEPTH), "more reads outstanding than queue depth")

endmodule

bind rotate_1bpp_frame_90_top rot90_chk u_chk (.*);
